// ----- rtl/assert_macros.svh -----
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ps2mt_pkg.sv -----
package ps2mt_pkg;

  localparam int COORD_W = 12;
  localparam int BTN_W   = 3;
  localparam int SEQ_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // packet queue depth between framer and tracker
  localparam int QUEUE_DEPTH = 2;

  // header bits
  localparam int HDR_SYNC_BIT  = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;

  localparam logic [COORD_W-1:0] MAX_X_RESET = 12'd1023;
  localparam logic [COORD_W-1:0] MAX_Y_RESET = 12'd767;
  localparam logic [COORD_W-1:0] POS_X_RESET = 12'd512;
  localparam logic [COORD_W-1:0] POS_Y_RESET = 12'd384;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y  = 2'd2;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_XDELTA,
    ST_YDELTA
  } frame_state_t;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // clamp a signed coordinate to 0..hi
  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [13:0] v,
                                                     input logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v[12:0] > {1'b0, hi}) begin
      res = hi;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/ps2mt_ifs.sv -----
interface ps2mt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ps2mt_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic [11:0] prev_x;
  logic [11:0] prev_y;
  logic [2:0]  buttons;
  logic [31:0] packet_count;

  modport source (output valid, output cursor_x, output cursor_y, output prev_x,
                  output prev_y, output buttons, output packet_count, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input prev_x,
                input prev_y, input buttons, input packet_count, output ready);
endinterface

// ----- rtl/ps2mt_front.sv -----
module ps2mt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                enable,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                in_ready,
  input  ps2mt_pkg::q_status_t q_status,
  output logic                push,
  output ps2mt_pkg::pkt_t     push_pkt
);

  ps2mt_pkg::frame_state_t state_r, state_nxt;
  logic [7:0] header_r;
  logic [7:0] x_byte_r;
  logic       active;
  logic       load_hdr;
  logic       load_x;

  assign in_ready = !q_status.full;
  assign active   = in_valid && in_ready && enable;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ps2mt_pkg::ST_HEADER: begin
        if (active && in_byte[ps2mt_pkg::HDR_SYNC_BIT]) state_nxt = ps2mt_pkg::ST_XDELTA;
      end
      ps2mt_pkg::ST_XDELTA: begin
        if (active) state_nxt = ps2mt_pkg::ST_YDELTA;
      end
      ps2mt_pkg::ST_YDELTA: begin
        if (active) state_nxt = ps2mt_pkg::ST_HEADER;
      end
      default: state_nxt = ps2mt_pkg::ST_HEADER;
    endcase
  end

  always_comb begin
    load_hdr = 1'b0;
    load_x   = 1'b0;
    push     = 1'b0;
    case (state_r)
      ps2mt_pkg::ST_HEADER: load_hdr = active && in_byte[ps2mt_pkg::HDR_SYNC_BIT];
      ps2mt_pkg::ST_XDELTA: load_x   = active;
      ps2mt_pkg::ST_YDELTA: push     = active;
      default: ;
    endcase
  end

  assign push_pkt = '{header: header_r, x_byte: x_byte_r, y_byte: in_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ps2mt_pkg::ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hdr) header_r <= in_byte;
    if (load_x) x_byte_r <= in_byte;
  end

endmodule

// ----- rtl/ps2mt_fifo.sv -----
module ps2mt_fifo #(
  parameter int DEPTH = ps2mt_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ps2mt_pkg::pkt_t      push_pkt,
  input  logic                 pop,
  output ps2mt_pkg::pkt_t      pop_pkt,
  output ps2mt_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ps2mt_pkg::pkt_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign pop_pkt = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop) rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_pkt;
  end

endmodule

// ----- rtl/ps2mt_back.sv -----
module ps2mt_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ps2mt_pkg::COORD_W-1:0]  max_x,
  input  logic [ps2mt_pkg::COORD_W-1:0]  max_y,
  input  ps2mt_pkg::q_status_t           q_status,
  input  ps2mt_pkg::pkt_t                pkt,
  output logic                           pop,
  ps2mt_out_if.source                    out_chan
);

  logic [ps2mt_pkg::COORD_W-1:0] pos_x_r, pos_y_r;
  logic [ps2mt_pkg::COORD_W-1:0] new_x, new_y;
  logic [ps2mt_pkg::SEQ_W-1:0]   seq_r, seq_nxt;
  logic                          out_valid_r;
  logic [ps2mt_pkg::COORD_W-1:0] out_x_r, out_y_r, prev_x_r, prev_y_r;
  logic [ps2mt_pkg::BTN_W-1:0]   btn_r;
  logic [ps2mt_pkg::SEQ_W-1:0]   out_seq_r;
  logic signed [13:0]            sum_x, sum_y;
  logic                          xs, ys;
  logic                          moves;

  assign pop = !q_status.empty && (!out_valid_r || out_chan.ready);

  assign xs = pkt.header[ps2mt_pkg::HDR_XSIGN_BIT];
  assign ys = pkt.header[ps2mt_pkg::HDR_YSIGN_BIT];

  // 9-bit deltas, screen y points down
  assign sum_x = $signed({2'b00, pos_x_r}) + $signed({{6{xs}}, pkt.x_byte});
  assign sum_y = $signed({2'b00, pos_y_r}) - $signed({{6{ys}}, pkt.y_byte});

  // overflow packets and zero motion leave the position alone
  assign moves = (pkt.header[7:6] == 2'b00) &&
                 ({xs, pkt.x_byte} != 9'd0 || {ys, pkt.y_byte} != 9'd0);

  assign new_x   = moves ? ps2mt_pkg::clamp_coord(sum_x, max_x) : pos_x_r;
  assign new_y   = moves ? ps2mt_pkg::clamp_coord(sum_y, max_y) : pos_y_r;
  assign seq_nxt = seq_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= ps2mt_pkg::POS_X_RESET;
      pos_y_r     <= ps2mt_pkg::POS_Y_RESET;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        pos_x_r     <= new_x;
        pos_y_r     <= new_y;
        seq_r       <= seq_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_x_r   <= new_x;
      out_y_r   <= new_y;
      prev_x_r  <= pos_x_r;
      prev_y_r  <= pos_y_r;
      btn_r     <= pkt.header[ps2mt_pkg::BTN_W-1:0];
      out_seq_r <= seq_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.cursor_x     = out_x_r;
  assign out_chan.cursor_y     = out_y_r;
  assign out_chan.prev_x       = prev_x_r;
  assign out_chan.prev_y       = prev_y_r;
  assign out_chan.buttons      = btn_r;
  assign out_chan.packet_count = out_seq_r;

endmodule

// ----- rtl/ps2_mouse_packet_tracker.sv -----
// channel   dir  ports                        payload
// in_chan   in   valid / ready / rx_byte      one byte from the mouse
// out_chan  out  valid / ready / fields       one item per completed packet
// cfg_*     in   cfg_we / cfg_index / cfg_wdata  enable, max_x, max_y
//
// one byte is taken every cycle while the packet queue is not full; the third byte of
// a packet is written into the queue when it is accepted, and the tracker pops it once
// the queue shows it and the output register is free, and loads that register
// the framer stalls only when the packet queue is full; the tracker stalls on out ready
// position update (sign extend, add, clamp) is combinational in the tracker
// rst_n is synchronous, active low; cursor returns to 512,384, count to 0
`include "assert_macros.svh"

module ps2_mouse_packet_tracker #(
  parameter int QUEUE_DEPTH = ps2mt_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ps2mt_in_if.sink                          in_chan,
  ps2mt_out_if.source                       out_chan,
  input  logic                              cfg_we,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ps2mt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic                          enable_r;
  logic [ps2mt_pkg::COORD_W-1:0] max_x_r;
  logic [ps2mt_pkg::COORD_W-1:0] max_y_r;

  // front to queue to back
  logic                 q_push;
  logic                 q_pop;
  ps2mt_pkg::pkt_t      q_in_pkt;
  ps2mt_pkg::pkt_t      q_out_pkt;
  ps2mt_pkg::q_status_t q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      max_x_r  <= ps2mt_pkg::MAX_X_RESET;
      max_y_r  <= ps2mt_pkg::MAX_Y_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ps2mt_pkg::REG_ENABLE: enable_r <= cfg_wdata[0];
        ps2mt_pkg::REG_MAX_X:  max_x_r  <= cfg_wdata[ps2mt_pkg::COORD_W-1:0];
        ps2mt_pkg::REG_MAX_Y:  max_y_r  <= cfg_wdata[ps2mt_pkg::COORD_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // framer: resync on header bit 3, collect three bytes, queue the packet
  ps2mt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .enable   (enable_r),
    .in_valid (in_chan.valid),
    .in_byte  (in_chan.rx_byte),
    .in_ready (in_chan.ready),
    .q_status (q_status),
    .push     (q_push),
    .push_pkt (q_in_pkt)
  );

  // short packet queue so framer and tracker stall independently
  ps2mt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_pkt (q_in_pkt),
    .pop      (q_pop),
    .pop_pkt  (q_out_pkt),
    .status   (q_status)
  );

  // tracker: buttons, clamped cursor, packet counter, output register
  ps2mt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .max_x    (max_x_r),
    .max_y    (max_y_r),
    .q_status (q_status),
    .pkt      (q_out_pkt),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

  // queue status is consistent
  `ASSERT_ALWAYS(a_q_status, !(q_status.full && q_status.empty), "queue full and empty")
  // a queued packet is visible to the tracker next cycle
  `ASSERT_NEXT(a_push_lands, q_push, !q_status.empty || $past(q_pop), "pushed packet lost")
  // every popped packet loads the output register
  `ASSERT_NEXT(a_pop_emits, q_pop, out_chan.valid, "popped packet not presented")

endmodule
